FILE: rtl/float_to_pcm16_with_level_stats_top_assert.svh
// Assertion macros shared by the float-to-PCM16 RTL.
// Each module that includes this file must have ports i_clk and i_rst_n.
`ifndef FLOAT_TO_PCM16_WITH_LEVEL_STATS_TOP_ASSERT_SVH
`define FLOAT_TO_PCM16_WITH_LEVEL_STATS_TOP_ASSERT_SVH

// Invariant checked at every clock edge outside reset.
`define F2P_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Trigger in one cycle implies a condition in the next.
`define F2P_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/f2p_pkg.sv
// Shared types and constants for the float-to-PCM16 converter.
// No dependencies; used by f2p_front, f2p_back and the top module.
`default_nettype none

package f2p_pkg;

    localparam int PEAK_FRAC_BITS_DEF = 23;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [14:0] PCM_SCALE          = 15'd32767;
    localparam logic [30:0] SAMPLE_LIMIT_RESET = 31'd2130706430;

    localparam logic [7:0] EXP_ONE = 8'd127;
    localparam logic [7:0] EXP_INF = 8'd255;

    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_CLEAR     = 2'd1,
        KIND_NONFINITE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONFINITE = 2'd1,
        ST_LIMIT     = 2'd2
    } t_status;

    // One classified item on its way from front to back.
    typedef struct packed {
        t_kind               kind;
        logic signed [15:0]  pcm;
        logic [30:0]         sq;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/f2p_fifo.sv
// Short item queue between the front and back parts.
// Depends on the assertion macro header only.
`default_nettype none

`include "float_to_pcm16_with_level_stats_top_assert.svh"

module f2p_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_ok && !rd_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_ok && !wr_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    `F2P_ASSERT(a_count_bound, r_count <= CNT_FULL, "queue count beyond depth")
    `F2P_ASSERT_NEXT(a_count_up, wr_ok && !rd_ok, r_count == $past(r_count) + CNT_W'(1), "queue count did not grow on write")

endmodule

`default_nettype wire

FILE: rtl/f2p_front.sv
// Front part: decodes the float32 sample, scales and rounds it to PCM16,
// truncates the magnitude and squares it. Uses f2p_pkg.
`default_nettype none

module f2p_front #(
    parameter int PEAK_FRAC_BITS = f2p_pkg::PEAK_FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    output logic                         o_full,
    input  wire logic                    i_cmd,
    input  wire logic [31:0]             i_sample_bits,
    output logic                         o_q_wr,
    output f2p_pkg::t_job                o_q_job,
    output logic [PEAK_FRAC_BITS:0]      o_q_mag,
    input  wire logic                    i_q_full
);

    localparam int MW    = PEAK_FRAC_BITS + 1;
    localparam int SW    = 24 + PEAK_FRAC_BITS;
    localparam int SQ_W  = 2 * MW;
    localparam int SQ_SH = 2 * PEAK_FRAC_BITS - 30;
    localparam int PR_W  = 39;

    // input decode
    logic [7:0]          exp_in;
    logic [23:0]         sig_in;
    logic [7:0]          k_in;
    logic                sat_in;
    f2p_pkg::t_kind      kind_in;
    logic [SW-1:0]       mag_shift;
    logic [MW-1:0]       mag_in;
    logic                en;
    logic                accept;

    // stage 1
    logic                r_s1_v;
    f2p_pkg::t_kind      r_s1_kind;
    logic                r_s1_neg;
    logic                r_s1_sat;
    logic [23:0]         r_s1_sig;
    logic [7:0]          r_s1_k;
    logic [MW-1:0]       r_s1_mag;

    // stage 2
    logic                r_s2_v;
    f2p_pkg::t_kind      r_s2_kind;
    logic                r_s2_neg;
    logic                r_s2_sat;
    logic [7:0]          r_s2_k;
    logic [PR_W-1:0]     r_s2_prod;
    logic [SQ_W-1:0]     r_s2_sq;
    logic [MW-1:0]       r_s2_mag;

    // rounding
    logic [5:0]          rnd_sh;
    logic [PR_W-1:0]     qg;
    logic [15:0]         q;
    logic                guard;
    logic                sticky;
    logic [15:0]         pmag;

    assign en     = !(r_s2_v && i_q_full);
    assign o_full = !en;
    assign accept = i_push && en;

    assign exp_in    = i_sample_bits[30:23];
    assign sig_in    = {(exp_in != 8'd0), i_sample_bits[22:0]};
    assign k_in      = (exp_in == 8'd0) ? 8'd149 : 8'd150 - exp_in;
    assign sat_in    = (exp_in >= f2p_pkg::EXP_ONE);
    assign mag_shift = {sig_in, {PEAK_FRAC_BITS{1'b0}}} >> k_in;
    assign mag_in    = sat_in ? (MW'(1) << PEAK_FRAC_BITS) : MW'(mag_shift);

    always_comb begin
        if (i_cmd) begin
            kind_in = f2p_pkg::KIND_CLEAR;
        end else if (exp_in == f2p_pkg::EXP_INF) begin
            kind_in = f2p_pkg::KIND_NONFINITE;
        end else begin
            kind_in = f2p_pkg::KIND_SAMPLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind <= kind_in;
            r_s1_neg  <= i_sample_bits[31];
            r_s1_sat  <= sat_in;
            r_s1_sig  <= sig_in;
            r_s1_k    <= k_in;
            r_s1_mag  <= mag_in;

            r_s2_kind <= r_s1_kind;
            r_s2_neg  <= r_s1_neg;
            r_s2_sat  <= r_s1_sat;
            r_s2_k    <= r_s1_k;
            r_s2_prod <= PR_W'(r_s1_sig) * PR_W'(f2p_pkg::PCM_SCALE);
            r_s2_sq   <= SQ_W'(r_s1_mag) * SQ_W'(r_s1_mag);
            r_s2_mag  <= r_s1_mag;
        end
    end

    // Round half to even of prod / 2^k; only 24 <= k < 40 can be nonzero.
    assign rnd_sh = 6'(r_s2_k - 8'd1);
    assign qg     = r_s2_prod >> rnd_sh;
    assign q      = qg[16:1];
    assign guard  = qg[0];
    assign sticky = |(r_s2_prod & ((PR_W'(1) << rnd_sh) - PR_W'(1)));

    always_comb begin
        if (r_s2_sat) begin
            pmag = 16'(f2p_pkg::PCM_SCALE);
        end else if (r_s2_k >= 8'd40) begin
            pmag = '0;
        end else begin
            pmag = q + 16'(guard && (sticky || q[0]));
        end
    end

    assign o_q_wr       = r_s2_v && !i_q_full;
    assign o_q_job.kind = r_s2_kind;
    assign o_q_job.pcm  = r_s2_neg ? -$signed(pmag) : $signed(pmag);
    assign o_q_job.sq   = 31'(r_s2_sq >> SQ_SH);
    assign o_q_mag      = r_s2_mag;

endmodule

`default_nettype wire

FILE: rtl/f2p_back.sv
// Back part: applies the length limit, updates peak, energy and count,
// and holds the result item in the output register. Uses f2p_pkg.
`default_nettype none

`include "float_to_pcm16_with_level_stats_top_assert.svh"

module f2p_back #(
    parameter int PEAK_FRAC_BITS = f2p_pkg::PEAK_FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_q_empty,
    input  wire f2p_pkg::t_job           i_q_job,
    input  wire logic [PEAK_FRAC_BITS:0] i_q_mag,
    output logic                         o_q_rd,
    input  wire logic [30:0]             i_limit,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output logic signed [15:0]           o_pcm,
    output logic [1:0]                   o_status,
    output logic [23:0]                  o_peak_level,
    output logic [63:0]                  o_energy,
    output logic [30:0]                  o_samples_done
);

    localparam int MW = PEAK_FRAC_BITS + 1;

    logic [MW-1:0]        r_peak, n_peak;
    logic [63:0]          r_energy, n_energy;
    logic [30:0]          r_count, n_count;
    logic                 r_out_v;
    logic signed [15:0]   r_out_pcm, n_pcm;
    f2p_pkg::t_status     r_out_status, n_status;
    logic [23:0]          r_out_peak;
    logic [63:0]          r_out_energy;
    logic [30:0]          r_out_count;
    logic [64:0]          sum;
    logic                 take;

    assign take   = !i_q_empty && (!r_out_v || i_pop);
    assign o_q_rd = take;
    assign sum    = {1'b0, r_energy} + 65'(i_q_job.sq);

    always_comb begin
        n_peak   = r_peak;
        n_energy = r_energy;
        n_count  = r_count;
        n_pcm    = '0;
        n_status = f2p_pkg::ST_OK;
        unique case (i_q_job.kind) inside
            f2p_pkg::KIND_CLEAR: begin
                n_peak   = '0;
                n_energy = '0;
                n_count  = '0;
            end
            f2p_pkg::KIND_SAMPLE, f2p_pkg::KIND_NONFINITE: begin
                // limit check takes precedence over the finiteness check
                if (r_count >= i_limit) begin
                    n_status = f2p_pkg::ST_LIMIT;
                end else if (i_q_job.kind == f2p_pkg::KIND_NONFINITE) begin
                    n_status = f2p_pkg::ST_NONFINITE;
                end else begin
                    n_pcm    = i_q_job.pcm;
                    n_peak   = (i_q_mag > r_peak) ? i_q_mag : r_peak;
                    n_energy = sum[64] ? '1 : sum[63:0];
                    n_count  = r_count + 31'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak   <= '0;
            r_energy <= '0;
            r_count  <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (take) begin
                r_peak   <= n_peak;
                r_energy <= n_energy;
                r_count  <= n_count;
                r_out_v  <= 1'b1;
            end else if (i_pop) begin
                r_out_v  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_pcm    <= n_pcm;
            r_out_status <= n_status;
            r_out_peak   <= 24'(n_peak);
            r_out_energy <= n_energy;
            r_out_count  <= n_count;
        end
    end

    assign o_empty        = !r_out_v;
    assign o_pcm          = r_out_pcm;
    assign o_status       = r_out_status;
    assign o_peak_level   = r_out_peak;
    assign o_energy       = r_out_energy;
    assign o_samples_done = r_out_count;

    `F2P_ASSERT_NEXT(a_clear_zeroes, take && i_q_job.kind == f2p_pkg::KIND_CLEAR, r_count == '0 && r_energy == '0 && r_peak == '0, "clear left statistics nonzero")
    `F2P_ASSERT_NEXT(a_ok_counts, take && i_q_job.kind == f2p_pkg::KIND_SAMPLE && n_status == f2p_pkg::ST_OK, r_count == $past(r_count) + 31'd1, "converted item not counted")

endmodule

`default_nettype wire

FILE: rtl/float_to_pcm16_with_level_stats_top.sv
// Top level of the float32 to PCM16 converter with level statistics.
// Instantiates f2p_front, f2p_fifo and f2p_back; uses f2p_pkg.
// Rate: one item per clock while full is low; an accepted item loads the first
// front stage, then the second front stage around the scaling and squaring
// multipliers, then the four-entry queue and finally the back's output
// register. Peak, energy and count update in the back as each item is taken
// into that register. Backpressure on pop fills the queue first; full rises
// when the queue is full while an item waits in the last front stage.
`default_nettype none

module float_to_pcm16_with_level_stats_top #(
    parameter int PEAK_FRAC_BITS = f2p_pkg::PEAK_FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [30:0]   i_cfg_data,
    input  wire logic          push,
    output logic               full,
    input  wire logic          i_cmd,
    input  wire logic [31:0]   i_sample_bits,
    output logic               empty,
    input  wire logic          pop,
    output logic signed [15:0] o_pcm,
    output logic [1:0]         o_status,
    output logic [23:0]        o_peak_level,
    output logic [63:0]        o_energy,
    output logic [30:0]        o_samples_done
);

    localparam int MW    = PEAK_FRAC_BITS + 1;
    localparam int JOB_W = $bits(f2p_pkg::t_job);
    localparam int QW    = MW + JOB_W;

    logic [30:0]       r_limit;
    logic              q_wr;
    logic              q_full;
    logic              q_rd;
    logic              q_empty;
    f2p_pkg::t_job     f_job;
    logic [MW-1:0]     f_mag;
    logic [QW-1:0]     q_rdata;
    f2p_pkg::t_job     b_job;
    logic [MW-1:0]     b_mag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= f2p_pkg::SAMPLE_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    f2p_front #(
        .PEAK_FRAC_BITS (PEAK_FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_sample_bits (i_sample_bits),
        .o_q_wr        (q_wr),
        .o_q_job       (f_job),
        .o_q_mag       (f_mag),
        .i_q_full      (q_full)
    );

    f2p_fifo #(
        .WIDTH (QW),
        .DEPTH (f2p_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata ({f_mag, f_job}),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign b_job = f2p_pkg::t_job'(q_rdata[JOB_W-1:0]);
    assign b_mag = q_rdata[QW-1:JOB_W];

    f2p_back #(
        .PEAK_FRAC_BITS (PEAK_FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_job        (b_job),
        .i_q_mag        (b_mag),
        .o_q_rd         (q_rd),
        .i_limit        (r_limit),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_pcm          (o_pcm),
        .o_status       (o_status),
        .o_peak_level   (o_peak_level),
        .o_energy       (o_energy),
        .o_samples_done (o_samples_done)
    );

endmodule

`default_nettype wire

FILE: tb/f2p_tb_pkg.sv
`timescale 1ns / 100ps
// Command codes shared by the converter testbench top and its checker.
// No dependencies.
package f2p_tb_pkg;

    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

endpackage

FILE: tb/f2p_level_checker.sv
`timescale 1ns / 100ps
// Checker for the float32 to PCM16 converter: tracks level statistics and
// predicts every result, then compares it with what the block pops.
// Depends on f2p_pkg (RTL) and f2p_tb_pkg.
module f2p_level_checker
    import f2p_pkg::*;
    import f2p_tb_pkg::*;
#(
    parameter int PEAK_FRAC_BITS = PEAK_FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_ready,
    input  wire logic [30:0]   i_cfg_data,
    input  wire logic          i_push,
    input  wire logic          i_full,
    input  wire logic          i_cmd,
    input  wire logic [31:0]   i_sample_bits,
    input  wire logic          i_empty,
    input  wire logic          i_pop,
    input  wire logic [15:0]   i_pcm,
    input  wire logic [1:0]    i_status,
    input  wire logic [23:0]   i_peak_level,
    input  wire logic [63:0]   i_energy,
    input  wire logic [30:0]   i_samples_done,
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct {
        logic signed [15:0] pcm;
        t_status            status;
        logic [23:0]        peak_level;
        logic [63:0]        energy;
        logic [30:0]        samples_done;
    } level_result_t;

    logic [23:0]   peak_mag;
    logic [63:0]   energy_sum;
    logic [30:0]   sample_count;
    logic [30:0]   sample_limit;
    level_result_t pending_results[$];
    int            fail_total = 0;

    // round-half-even of sig * 32767 / 2^k
    function automatic logic [15:0] scale_to_pcm(input logic [23:0] sig, input int unsigned k);
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (k > 40)
            return 16'd0;
        prod = 64'(sig) * 64'(PCM_SCALE);
        q    = prod >> k;
        rem  = prod & ((64'd1 << k) - 64'd1);
        half = 64'd1 << (k - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q[15:0];
    endfunction

    function automatic level_result_t convert_and_account(input logic cmd,
                                                          input logic [31:0] bits);
        logic          neg;
        logic [7:0]    ex;
        logic [23:0]   sig;
        int unsigned   k;
        logic [15:0]   pmag;
        logic [63:0]   mag;
        logic [63:0]   sq;
        level_result_t r;
        neg      = bits[31];
        ex       = bits[30:23];
        r.pcm    = 16'sd0;
        r.status = ST_OK;
        if (cmd == CMD_CLEAR) begin
            peak_mag     = '0;
            energy_sum   = '0;
            sample_count = '0;
        end else if (sample_count >= sample_limit) begin
            r.status = ST_LIMIT;
        end else if (ex == EXP_INF) begin
            r.status = ST_NONFINITE;
        end else begin
            if (ex >= EXP_ONE) begin
                pmag = 16'(PCM_SCALE);
                mag  = 64'd1 << PEAK_FRAC_BITS;
            end else begin
                sig  = (ex == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
                k    = (ex == 8'd0) ? 149 : 150 - int'(ex);
                pmag = scale_to_pcm(sig, k);
                mag  = (k < 64) ? ((64'(sig) << PEAK_FRAC_BITS) >> k) : 64'd0;
            end
            if (mag > 64'(peak_mag))
                peak_mag = mag[23:0];
            sq = (mag * mag) >> (2 * PEAK_FRAC_BITS - 30);
            // saturates at all ones
            if (energy_sum > ~64'd0 - sq)
                energy_sum = ~64'd0;
            else
                energy_sum = energy_sum + sq;
            sample_count = sample_count + 31'd1;
            r.pcm = neg ? -$signed(pmag) : $signed(pmag);
        end
        r.peak_level   = peak_mag;
        r.energy       = energy_sum;
        r.samples_done = sample_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        level_result_t want;
        if (!i_rst_n) begin
            peak_mag     = '0;
            energy_sum   = '0;
            sample_count = '0;
            sample_limit = SAMPLE_LIMIT_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                sample_limit = i_cfg_data;
            if (i_push && !i_full)
                pending_results.push_back(convert_and_account(i_cmd, i_sample_bits));
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    $error("result popped with no item waiting for it");
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("pcm", 64'(want.pcm), 64'($signed(i_pcm)));
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("peak_level", 64'(want.peak_level), 64'(i_peak_level));
                    check_field("energy", want.energy, i_energy);
                    check_field("samples_done", 64'(want.samples_done), 64'(i_samples_done));
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for float_to_pcm16_with_level_stats_top: drives samples, clears
// and limit writes under several idling patterns. Uses f2p_level_checker.
module tb;
    import f2p_pkg::*;
    import f2p_tb_pkg::*;

    localparam int RANDOM_PER_PHASE = 160;

    // extremes, clamps, non-finite values, the rounding tie and the
    // cutoff where the scaled value drops below one half
    localparam logic [31:0] EDGE_SAMPLES [19] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
        32'h3F80_0000, 32'hBF80_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
        32'h4000_0000, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3F00_0000, 32'hBF00_0000,
        32'h377F_FFFF, 32'h36FF_FFFF, 32'h3F40_0000
    };

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [30:0]   cfg_data = '0;
    logic          push = 1'b0;
    logic          full;
    logic          cmd = CMD_CONVERT;
    logic [31:0]   sample_bits = '0;
    logic          empty;
    logic          pop = 1'b0;
    logic [15:0]   pcm;
    logic [1:0]    status;
    logic [23:0]   peak_level;
    logic [63:0]   energy;
    logic [30:0]   samples_done;
    int            pending;
    int            fail_count;
    int            send_idle_pct = 0;
    int            pop_stall_pct = 0;
    int            n_items = 0;
    int            n_clears = 0;
    int            n_cfg = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    float_to_pcm16_with_level_stats_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .push           (push),
        .full           (full),
        .i_cmd          (cmd),
        .i_sample_bits  (sample_bits),
        .empty          (empty),
        .pop            (pop),
        .o_pcm          (pcm),
        .o_status       (status),
        .o_peak_level   (peak_level),
        .o_energy       (energy),
        .o_samples_done (samples_done)
    );

    f2p_level_checker level_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_cmd          (cmd),
        .i_sample_bits  (sample_bits),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_pcm          (pcm),
        .i_status       (status),
        .i_peak_level   (peak_level),
        .i_energy       (energy),
        .i_samples_done (samples_done),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // mostly in-range samples near full scale, plus clamps, tiny values,
    // subnormals, non-finite patterns and raw noise
    function automatic logic [31:0] random_sample_bits();
        int unsigned pick;
        logic [7:0]  ex;
        logic [22:0] man;
        pick = $urandom_range(99);
        man  = 23'($urandom);
        if ($urandom_range(7) == 0)
            man = ($urandom_range(1) == 0) ? '0 : '1;
        if (pick < 45)
            ex = 8'($urandom_range(126, 112));
        else if (pick < 60)
            ex = 8'($urandom_range(254, 127));
        else if (pick < 70)
            ex = 8'($urandom_range(111, 1));
        else if (pick < 76)
            ex = 8'd0;
        else if (pick < 83)
            ex = EXP_INF;
        else if (pick < 90)
            ex = EXP_ONE - 8'd1;
        else
            return $urandom;
        return {1'($urandom_range(1)), ex, man};
    endfunction

    task automatic send_item(input logic cmd_v, input logic [31:0] bits_v);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        cmd         <= cmd_v;
        sample_bits <= bits_v;
        do @(posedge clk); while (full);
        n_items++;
        if (cmd_v == CMD_CLEAR)
            n_clears++;
    endtask

    task automatic finish_pending();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_sample_limit(input logic [30:0] limit_v);
        cfg_valid <= 1'b1;
        cfg_data  <= limit_v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    initial begin
        logic [30:0] limit_v;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_CLEAR, 32'h0000_0000);
        foreach (EDGE_SAMPLES[i])
            send_item(CMD_CONVERT, EDGE_SAMPLES[i]);
        send_item(CMD_CLEAR, 32'hFFFF_FFFF);
        send_item(CMD_CONVERT, 32'hBE80_0001);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0, 5:    limit_v = 31'($urandom_range(40, 5));
                1:       limit_v = '0;
                2:       limit_v = 31'($urandom_range(SAMPLE_LIMIT_RESET));
                4:       limit_v = 31'd1;
                6:       limit_v = 31'($urandom_range(SAMPLE_LIMIT_RESET, 1 << 24));
                default: limit_v = SAMPLE_LIMIT_RESET;
            endcase
            finish_pending();
            write_sample_limit(limit_v);
            case (p % 4)
                0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1:       begin send_idle_pct = 60; pop_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  pop_stall_pct = 60; end
                default: begin send_idle_pct = 7;  pop_stall_pct = 7;  end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_item(($urandom_range(99) < 4) ? CMD_CLEAR : CMD_CONVERT,
                          random_sample_bits());
        end

        finish_pending();
        repeat (8) @(posedge clk);
        $display("Sent %0d items (%0d clears) across %0d sample limit settings,",
                 n_items, n_clears, n_cfg);
        $display("under four idle/stall patterns on both handshakes.");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
